// ===== design/first_fit_note_track_allocator_top_macros.svh =====
// Assertion macros used by the allocator datapath.
`ifndef FIRST_FIT_NOTE_TRACK_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_NOTE_TRACK_ALLOCATOR_TOP_MACROS_SVH

// Checked on every rising edge outside reset.
`define FFNTA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ffnta assertion failed");

// Checked on every rising edge, reset included.
`define FFNTA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("ffnta assertion failed");

`endif

// ===== design/ffnta_pkg.sv =====
package ffnta_pkg;

    localparam int TRACK_IDX_W = 4;
    localparam int CFG_W       = 4;
    localparam int TICK_W      = 32;
    localparam logic [CFG_W-1:0] TRACKS_IN_USE_RESET = 4'd12;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_end;
        logic out_free;
    } t_status;

endpackage

// ===== design/ffnta_ctrl.sv =====
module ffnta_ctrl
    import ffnta_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.scan_end) begin
                    n_state = ST_DECIDE;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_DECIDE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/ffnta_lane.sv =====
module ffnta_lane
    import ffnta_pkg::*;
#(
    parameter int NOTES_PER_TRACK = 256,
    parameter int AW = $clog2(NOTES_PER_TRACK),
    parameter int FW = $clog2(NOTES_PER_TRACK + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_rd_en,
    input  logic [FW-1:0]     i_rd_idx,
    input  logic              i_wr_en,
    input  logic [TICK_W-1:0] i_start,
    input  logic [TICK_W-1:0] i_end,
    output logic              o_conflict,
    output logic [FW-1:0]     o_fill
);

    logic [TICK_W-1:0] r_start_mem [NOTES_PER_TRACK];
    logic [TICK_W-1:0] r_end_mem [NOTES_PER_TRACK];
    logic [TICK_W-1:0] r_s;
    logic [TICK_W-1:0] r_e;
    logic              r_rd_vld;
    logic              r_conflict;
    logic [FW-1:0]     r_fill;
    logic              overlap;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_start_mem[r_fill[AW-1:0]] <= i_start;
            r_end_mem[r_fill[AW-1:0]]   <= i_end;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s <= r_start_mem[i_rd_idx[AW-1:0]];
        r_e <= r_end_mem[i_rd_idx[AW-1:0]];
    end

    assign overlap = (r_e >= i_start && r_e <= i_end)
                  || (r_s >= i_start && r_s <= i_end)
                  || (r_s <= i_start && r_e >= i_end)
                  || (r_s >= i_start && r_e <= i_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_conflict <= 1'b0;
            r_fill     <= '0;
        end else begin
            r_rd_vld <= i_rd_en && (i_rd_idx < r_fill);
            if (i_clear) begin
                r_conflict <= 1'b0;
            end else if (r_rd_vld && overlap) begin
                r_conflict <= 1'b1;
            end
            if (i_wr_en) begin
                r_fill <= r_fill + FW'(1);
            end
        end
    end

    assign o_conflict = r_conflict;
    assign o_fill     = r_fill;

endmodule

// ===== design/ffnta_datapath.sv =====
`include "first_fit_note_track_allocator_top_macros.svh"

module ffnta_datapath
    import ffnta_pkg::*;
#(
    parameter int TRACK_COUNT     = 12,
    parameter int NOTES_PER_TRACK = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    input  logic [TICK_W-1:0]      i_start_tick,
    input  logic [TICK_W-1:0]      i_end_tick,
    input  logic                   i_cfg_valid,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   i_out_stall,
    output logic                   o_out_valid,
    output logic [TRACK_IDX_W-1:0] o_track_index,
    output logic                   o_dropped,
    output logic                   o_store_full_seen
);

    localparam int FW = $clog2(NOTES_PER_TRACK + 1);
    localparam logic [FW-1:0] FULL_CNT = FW'(NOTES_PER_TRACK);
    localparam logic [CFG_W:0] TC = (CFG_W + 1)'(TRACK_COUNT);

    logic [TICK_W-1:0]      r_start;
    logic [TICK_W-1:0]      r_end;
    logic [FW-1:0]          r_idx;
    logic [FW-1:0]          r_max_fill;
    logic [CFG_W-1:0]       r_tracks_in_use;
    logic                   r_out_valid;
    logic [TRACK_IDX_W-1:0] r_track_index;
    logic                   r_dropped;
    logic                   r_full_seen;

    logic [TRACK_COUNT-1:0] conflict;
    logic [FW-1:0]          fill [TRACK_COUNT];
    logic [TRACK_COUNT-1:0] wr_en;

    logic [CFG_W:0]         limit;
    logic                   placed;
    logic                   full_seen;
    logic [TRACK_IDX_W-1:0] chosen;
    logic [FW-1:0]          chosen_fill;

    for (genvar t = 0; t < TRACK_COUNT; t++) begin : g_lane
        assign wr_en[t] = i_cmd.commit && placed && (chosen == TRACK_IDX_W'(t));
        ffnta_lane #(
            .NOTES_PER_TRACK(NOTES_PER_TRACK)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_clear   (i_cmd.load),
            .i_rd_en   (i_cmd.step),
            .i_rd_idx  (r_idx),
            .i_wr_en   (wr_en[t]),
            .i_start   (r_start),
            .i_end     (r_end),
            .o_conflict(conflict[t]),
            .o_fill    (fill[t])
        );
    end

    always_comb begin
        if (r_tracks_in_use == '0) begin
            limit = (CFG_W + 1)'(1);
        end else if ({1'b0, r_tracks_in_use} > TC) begin
            limit = TC;
        end else begin
            limit = {1'b0, r_tracks_in_use};
        end
    end

    always_comb begin
        placed      = 1'b0;
        full_seen   = 1'b0;
        chosen      = '0;
        chosen_fill = '0;
        for (int t = 0; t < TRACK_COUNT; t++) begin
            if ((CFG_W + 1)'(t) < limit && !placed && !conflict[t]) begin
                if (fill[t] >= FULL_CNT) begin
                    full_seen = 1'b1;
                end else begin
                    placed      = 1'b1;
                    chosen      = TRACK_IDX_W'(t);
                    chosen_fill = fill[t];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_start <= i_start_tick;
            r_end   <= i_end_tick;
        end
        if (i_cmd.commit) begin
            r_track_index <= chosen;
            r_dropped     <= !placed;
            r_full_seen   <= full_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx           <= '0;
            r_max_fill      <= '0;
            r_tracks_in_use <= TRACKS_IN_USE_RESET;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_tracks_in_use <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.step) begin
                r_idx <= r_idx + FW'(1);
            end
            if (i_cmd.commit && placed && (chosen_fill + FW'(1) > r_max_fill)) begin
                r_max_fill <= chosen_fill + FW'(1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.scan_end = (r_idx >= r_max_fill);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid       = r_out_valid;
    assign o_track_index     = r_track_index;
    assign o_dropped         = r_dropped;
    assign o_store_full_seen = r_full_seen;

    `FFNTA_ASSERT(a_commit_slot_free, i_clk, i_rst_n, i_cmd.commit |-> o_status.out_free)
    `FFNTA_ASSERT(a_commit_sets_valid, i_clk, i_rst_n, i_cmd.commit |=> r_out_valid)
    `FFNTA_ASSERT(a_step_in_range, i_clk, i_rst_n, i_cmd.step |-> (r_idx < r_max_fill))
    `FFNTA_ASSERT(a_max_fill_bound, i_clk, i_rst_n, r_max_fill <= FULL_CNT)
    `FFNTA_ASSERT_ALWAYS(a_cmd_exclusive, i_clk, $onehot0({i_cmd.load, i_cmd.step, i_cmd.commit}))

endmodule

// ===== design/first_fit_note_track_allocator_top.sv =====
// Channel  Direction  Handshake            Payload
// in       input      i_in_valid/o_in_stall    i_start_tick, i_end_tick
// out      output     o_out_valid/i_out_stall  o_track_index, o_dropped, o_store_full_seen
// cfg      input      i_cfg_valid/o_cfg_ready  i_cfg_data (tracks in use)
//
// A request is loaded, then scanned over F stored slots, where F is the largest fill
// count of any track; each scan cycle reads one stored interval from every track memory.
// The result commits once the output register is free; a request is taken only when idle.
// Synchronous active-low reset empties every track and sets tracks in use to twelve.
// A result waits in the output register while stalled; the next request may be accepted
// meanwhile and the controller holds it in the decide state until the register is free.
module first_fit_note_track_allocator_top
    import ffnta_pkg::*;
#(
    parameter int TRACK_COUNT     = 12,
    parameter int NOTES_PER_TRACK = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [TICK_W-1:0]      i_start_tick,
    input  logic [TICK_W-1:0]      i_end_tick,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [TRACK_IDX_W-1:0] o_track_index,
    output logic                   o_dropped,
    output logic                   o_store_full_seen,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    ffnta_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_in_stall(o_in_stall)
    );

    ffnta_datapath #(
        .TRACK_COUNT    (TRACK_COUNT),
        .NOTES_PER_TRACK(NOTES_PER_TRACK)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_start_tick     (i_start_tick),
        .i_end_tick       (i_end_tick),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_track_index    (o_track_index),
        .o_dropped        (o_dropped),
        .o_store_full_seen(o_store_full_seen)
    );

endmodule
